### rtl/ufpp_pkg.sv
// Package for the fragment payload packetizer: fixed buffer geometry,
// header size, and the state and result structs shared by the core and the top level.
// No dependencies.
`default_nettype none

package ufpp_pkg;

  localparam int unsigned BufferBytes = 20480;
  localparam int unsigned BufferCount = 4;
  localparam int unsigned FrameBytes  = 614400;
  localparam int unsigned LineBytes   = 1280;
  localparam int unsigned BufferLines = 16;
  localparam int unsigned HeaderBytes = 12;

  // The reader is behind when it trails the producer by more than this many lines.
  localparam logic [31:0] LagLimit = 32'(BufferLines + BufferLines / 2);

  localparam logic [11:0] MaxPayloadReset = 12'd3072;

  // The position is carried in several forms, so that no division is needed at run time.
  typedef struct packed {
    logic [19:0] frame_pos;    // byte position within the frame
    logic [14:0] pos_in_buf;   // frame_pos modulo BufferBytes
    logic [8:0]  reader_line;  // frame_pos divided by LineBytes
    logic [10:0] line_rem;     // frame_pos modulo LineBytes
    logic [1:0]  drain_idx;
    logic        frame_id;
  } state_t;

  typedef struct packed {
    logic [11:0]        payload_length;
    logic [1:0]         buffer_index;
    logic signed [15:0] start_offset;
    logic               frame_id;
    logic               end_of_frame;
    logic               buffer_consumed;
    logic               resync;
  } result_t;

endpackage

`default_nettype wire

### rtl/ufpp_core.sv
// Combinational payload decision: computes one result and the next position state
// from the current state, one request and the maximum payload register.
// Depends on ufpp_pkg.
`default_nettype none

module ufpp_core (
  input  ufpp_pkg::state_t  state_i,
  input  logic [31:0]       producer_line_i,
  input  logic [2:0]        buffers_ready_i,
  input  logic [11:0]       max_payload_i,
  output ufpp_pkg::result_t result_o,
  output ufpp_pkg::state_t  state_o
);

  logic [31:0] lag;
  logic        lagging;
  logic [11:0] data_max;
  logic [14:0] room;
  logic [11:0] send;
  logic [14:0] pos_sum;
  logic [19:0] fpos_sum;
  logic        consumed;
  logic        frame_done;
  logic [12:0] line_sum;
  logic [2:0]  line_q;
  logic [10:0] line_rem_nxt;
  logic [1:0]  drain_nxt;

  assign lag     = producer_line_i - {23'd0, state_i.reader_line};
  assign lagging = lag > ufpp_pkg::LagLimit;

  assign data_max = (max_payload_i > 12'(ufpp_pkg::HeaderBytes))
                    ? max_payload_i - 12'(ufpp_pkg::HeaderBytes) : 12'd0;
  assign room     = 15'(ufpp_pkg::BufferBytes) - state_i.pos_in_buf;
  assign send     = (room > {3'd0, data_max}) ? data_max : room[11:0];

  // A payload never crosses a buffer boundary, so the buffer is drained exactly
  // when the sum lands on its end, and the frame can only end on such a payload.
  assign pos_sum    = state_i.pos_in_buf + {3'd0, send};
  assign consumed   = pos_sum >= 15'(ufpp_pkg::BufferBytes);
  assign fpos_sum   = state_i.frame_pos + {8'd0, send};
  assign frame_done = consumed && (fpos_sum >= 20'(ufpp_pkg::FrameBytes));
  assign drain_nxt  = (state_i.drain_idx >= 2'(ufpp_pkg::BufferCount - 1))
                      ? 2'd0 : state_i.drain_idx + 2'd1;

  // One payload moves the line count forward by at most four lines.
  assign line_sum = {2'd0, state_i.line_rem} + {1'b0, send};

  always_comb begin
    if (line_sum >= 13'(4 * ufpp_pkg::LineBytes)) begin
      line_q       = 3'd4;
      line_rem_nxt = 11'(line_sum - 13'(4 * ufpp_pkg::LineBytes));
    end else if (line_sum >= 13'(3 * ufpp_pkg::LineBytes)) begin
      line_q       = 3'd3;
      line_rem_nxt = 11'(line_sum - 13'(3 * ufpp_pkg::LineBytes));
    end else if (line_sum >= 13'(2 * ufpp_pkg::LineBytes)) begin
      line_q       = 3'd2;
      line_rem_nxt = 11'(line_sum - 13'(2 * ufpp_pkg::LineBytes));
    end else if (line_sum >= 13'(ufpp_pkg::LineBytes)) begin
      line_q       = 3'd1;
      line_rem_nxt = 11'(line_sum - 13'(ufpp_pkg::LineBytes));
    end else begin
      line_q       = 3'd0;
      line_rem_nxt = line_sum[10:0];
    end
  end

  always_comb begin
    result_o = '0;
    state_o  = state_i;
    if (buffers_ready_i != 3'd0) begin
      if (lagging) begin
        state_o.frame_pos   = '0;
        state_o.pos_in_buf  = '0;
        state_o.reader_line = '0;
        state_o.line_rem    = '0;
        state_o.drain_idx   = '0;
        result_o.resync     = 1'b1;
      end else begin
        result_o.payload_length  = 12'(ufpp_pkg::HeaderBytes) + send;
        result_o.buffer_index    = state_i.drain_idx;
        result_o.start_offset    = {1'b0, state_i.pos_in_buf} - 16'(ufpp_pkg::HeaderBytes);
        result_o.frame_id        = state_i.frame_id;
        result_o.buffer_consumed = consumed;
        result_o.end_of_frame    = frame_done;

        state_o.frame_pos   = fpos_sum;
        state_o.pos_in_buf  = consumed ? 15'd0 : pos_sum;
        state_o.reader_line = state_i.reader_line + {6'd0, line_q};
        state_o.line_rem    = line_rem_nxt;
        state_o.drain_idx   = consumed ? drain_nxt : state_i.drain_idx;
        if (frame_done) begin
          state_o.frame_pos   = '0;
          state_o.pos_in_buf  = '0;
          state_o.reader_line = '0;
          state_o.line_rem    = '0;
          state_o.drain_idx   = '0;
          state_o.frame_id    = ~state_i.frame_id;
        end
      end
    end
  end

endmodule

`default_nettype wire

### rtl/uvc_fragment_payload_packetizer_top.sv
// Top level of the fragment payload packetizer: input register, position state,
// maximum payload register and output register around the ufpp_core logic.
// Depends on ufpp_pkg and ufpp_core.
//
//  Channel | Direction | Handshake                    | Contents
//  --------+-----------+------------------------------+------------------------------
//  s_axis  | in        | s_axis_tvalid/s_axis_tready  | one payload request
//  m_axis  | out       | m_axis_tvalid/m_axis_tready  | one payload descriptor
//  cfg     | in        | cfg_valid_i/cfg_ready_o      | max_payload register write
//
// One request is taken per clock cycle while s_axis_tready is high; its result moves from the
// input register through the core into the output register, which drives m_axis.
// The position state updates in the cycle that the request moves from the input
// register into the output register.
// Reset clears the state and the valid flags and sets max_payload to 3072.
// Input ready drops only while both registers are full and m_axis_tready is low.
`default_nettype none

module uvc_fragment_payload_packetizer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [31:0] producer_line, [34:32] buffers_ready, zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [11:0] payload_length, [13:12] buffer_index, [29:14] start_offset,
  // [30] frame_id, [31] buffer_consumed
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast,   // end_of_frame
  output logic        m_axis_tuser,   // [0] resync
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [11:0] cfg_data_i
);

  logic              in_vld_q;
  logic [31:0]       in_line_q;
  logic [2:0]        in_ready_cnt_q;
  logic              out_vld_q;
  ufpp_pkg::result_t out_q;
  ufpp_pkg::result_t result_d;
  ufpp_pkg::state_t  state_q;
  ufpp_pkg::state_t  state_d;
  logic [11:0]       max_payload_q;
  logic              advance;

  assign advance       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || advance;
  assign cfg_ready_o   = 1'b1;

  ufpp_core u_core (
    .state_i         (state_q),
    .producer_line_i (in_line_q),
    .buffers_ready_i (in_ready_cnt_q),
    .max_payload_i   (max_payload_q),
    .result_o        (result_d),
    .state_o         (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= ufpp_pkg::MaxPayloadReset;
    end else if (cfg_valid_i) begin
      max_payload_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_vld_q <= in_vld_q;
      end
      if (advance && in_vld_q) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_line_q      <= s_axis_tdata[31:0];
      in_ready_cnt_q <= s_axis_tdata[34:32];
    end
    if (advance && in_vld_q) begin
      out_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q.buffer_consumed, out_q.frame_id, out_q.start_offset,
                          out_q.buffer_index, out_q.payload_length};
  assign m_axis_tlast  = out_q.end_of_frame;
  assign m_axis_tuser  = out_q.resync;

endmodule

`default_nettype wire

### rtl/ufpp_checker.sv
// Port-level checker for the fragment payload packetizer, bound to the top level.
// Watches only the result stream ports; no package dependency.
`default_nettype none

module ufpp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);

  // A stalled result holds until its transaction completes.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // A resync result carries nothing else.
  a_resync_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 32'd0 && !m_axis_tlast)
    else $error("resync result with payload fields set");

  // A frame can only end on the payload that drains its last buffer.
  a_eof_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[31] && m_axis_tdata[11:0] != 12'd0)
    else $error("end of frame without buffer drained");

  // An empty payload is either the not-ready answer or a resync, both all zero.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[11:0] == 12'd0 |-> m_axis_tdata == 32'd0)
    else $error("zero-length payload with fields set");

endmodule

bind uvc_fragment_payload_packetizer_top ufpp_checker u_ufpp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

### tb/ufpp_payload_checker.sv
// Checker for the fragment payload packetizer: watches the request, descriptor and
// max_payload channels, predicts every descriptor and compares it field by field.
// Depends on ufpp_pkg.
module ufpp_payload_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [31:0] producer_line, [34:32] buffers_ready, zero pad
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [11:0] payload_length, [13:12] buffer_index, [29:14] start_offset,
  // [30] frame_id, [31] buffer_consumed
  input  logic [31:0] m_axis_tdata,
  input  logic        m_axis_tlast,   // end_of_frame
  input  logic        m_axis_tuser,   // [0] resync
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [11:0] cfg_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output logic [31:0] reader_line_o,
  output int unsigned descriptors_o,
  output int unsigned frame_ends_o,
  output int unsigned resyncs_o
);

  logic [19:0] frame_pos   = '0;
  logic [1:0]  drain_idx   = '0;
  logic        frame_id    = 1'b0;
  logic [11:0] max_payload = ufpp_pkg::MaxPayloadReset;

  ufpp_pkg::result_t expected_payloads [$];
  int unsigned fails       = 0;
  int unsigned descriptors = 0;
  int unsigned frame_ends  = 0;
  int unsigned resyncs     = 0;

  assign fail_count_o  = fails;
  assign pending_o     = expected_payloads.size();
  assign reader_line_o = 32'(frame_pos / ufpp_pkg::LineBytes);
  assign descriptors_o = descriptors;
  assign frame_ends_o  = frame_ends;
  assign resyncs_o     = resyncs;

  // Works out the descriptor for one request and advances the position state.
  function automatic ufpp_pkg::result_t predict_payload(logic [31:0] prod_line,
                                                        logic [2:0]  ready);
    ufpp_pkg::result_t res;
    logic [31:0] lag;
    int unsigned in_buf;
    int unsigned room;
    int unsigned data_max;
    int unsigned send;
    res = '0;
    if (ready == 3'd0) return res;
    lag = prod_line - 32'(frame_pos / ufpp_pkg::LineBytes);
    if (lag > ufpp_pkg::LagLimit) begin
      frame_pos  = '0;
      drain_idx  = '0;
      res.resync = 1'b1;
      return res;
    end
    in_buf   = frame_pos % ufpp_pkg::BufferBytes;
    room     = ufpp_pkg::BufferBytes - in_buf;
    data_max = (max_payload > ufpp_pkg::HeaderBytes)
               ? max_payload - ufpp_pkg::HeaderBytes : 0;
    send     = (room > data_max) ? data_max : room;
    res.payload_length = 12'(ufpp_pkg::HeaderBytes + send);
    res.buffer_index   = drain_idx;
    // The header sits just before the data, so the offset goes negative at a buffer start.
    res.start_offset   = 16'(in_buf - ufpp_pkg::HeaderBytes);
    res.frame_id       = frame_id;
    frame_pos = 20'(frame_pos + send);
    if (in_buf + send >= ufpp_pkg::BufferBytes) begin
      res.buffer_consumed = 1'b1;
      drain_idx = (drain_idx == 2'(ufpp_pkg::BufferCount - 1))
                  ? 2'd0 : drain_idx + 2'd1;
      if (frame_pos >= ufpp_pkg::FrameBytes) begin
        frame_pos        = '0;
        res.end_of_frame = 1'b1;
        frame_id         = ~frame_id;
        drain_idx        = '0;
      end
    end
    return res;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i) begin : watch
    ufpp_pkg::result_t want;
    if (!rst_ni) begin
      frame_pos   = '0;
      drain_idx   = '0;
      frame_id    = 1'b0;
      max_payload = ufpp_pkg::MaxPayloadReset;
      expected_payloads.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) max_payload = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_payloads.push_back(predict_payload(s_axis_tdata[31:0], s_axis_tdata[34:32]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_payloads.size() == 0) begin
          $error("descriptor 0x%08h arrived with no request outstanding", m_axis_tdata);
          fails++;
        end else begin
          want = expected_payloads.pop_front();
          descriptors++;
          if (want.end_of_frame) frame_ends++;
          if (want.resync) resyncs++;
          check_field("payload_length", want.payload_length, m_axis_tdata[11:0]);
          check_field("buffer_index", want.buffer_index, m_axis_tdata[13:12]);
          check_field("start_offset", want.start_offset, $signed(m_axis_tdata[29:14]));
          check_field("frame_id", want.frame_id, m_axis_tdata[30]);
          check_field("buffer_consumed", want.buffer_consumed, m_axis_tdata[31]);
          check_field("end_of_frame", want.end_of_frame, m_axis_tlast);
          check_field("resync", want.resync, m_axis_tuser);
        end
      end
    end
  end

endmodule

### tb/tb_top.sv
// Testbench top for the fragment payload packetizer: clock, reset, request and
// max_payload stimulus, descriptor back-pressure and the final verdict.
// Depends on ufpp_pkg, uvc_fragment_payload_packetizer_top and ufpp_payload_checker.
module tb_top;

  localparam int unsigned CycleLimit = 200000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [11:0] cfg_data_i    = '0;

  int unsigned fail_count;
  int unsigned pending_results;
  logic [31:0] reader_line;
  int unsigned descriptors;
  int unsigned frame_ends;
  int unsigned resyncs;

  int unsigned requests  = 0;
  int unsigned cycles    = 0;
  int unsigned hold_off  = 0;
  bit          bursts_on = 1'b1;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  uvc_fragment_payload_packetizer_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  ufpp_payload_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending_results),
    .reader_line_o(reader_line),
    .descriptors_o(descriptors),
    .frame_ends_o (frame_ends),
    .resyncs_o    (resyncs)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $error("timeout after %0d cycles with %0d descriptors outstanding", cycles,
             pending_results);
      $display("uvc_fragment_payload_packetizer_top: mismatch");
      $finish;
    end
  end

  // Descriptor side: one assignment per burst, bursts of back-pressure or readiness.
  always begin : receiver
    @(negedge clk_i);
    if (hold_off != 0) begin
      m_axis_tready <= 1'b0;
      repeat (hold_off) @(negedge clk_i);
      hold_off = 0;
    end else if (bursts_on && $urandom_range(0, 2) == 0) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(1, 8) - 1) @(negedge clk_i);
    end else begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 16) - 1) @(negedge clk_i);
    end
  end

  // The producer line is either absolute or taken relative to the predicted reader line,
  // which lets the stimulus stay inside the lag window.
  task automatic offer_request(input logic [2:0] ready, input logic [31:0] line,
                               input bit absolute);
    logic [31:0] prod_line;
    prod_line = absolute ? line : reader_line + line;
    s_axis_tdata  <= {5'd0, ready, prod_line};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    requests++;
  endtask

  task automatic random_request(input int unsigned empty_pct, input int unsigned behind_pct);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < empty_pct) begin
      offer_request(3'd0, $urandom, 1'b1);
    end else if (pick < empty_pct + behind_pct) begin
      case ($urandom_range(0, 2))
        0:       offer_request(3'($urandom_range(1, 7)), $urandom, 1'b1);
        1:       offer_request(3'($urandom_range(1, 7)), 32'($urandom_range(25, 64)), 1'b0);
        default: offer_request(3'($urandom_range(1, 7)), -32'($urandom_range(1, 3)), 1'b0);
      endcase
    end else begin
      offer_request(3'($urandom_range(1, 7)), 32'($urandom_range(0, 24)), 1'b0);
    end
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results != 0) @(negedge clk_i);
  endtask

  task automatic write_max_payload(input logic [11:0] value);
    wait_drained();
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [11:0] value, input int unsigned count,
                           input int unsigned empty_pct, input int unsigned behind_pct);
    write_max_payload(value);
    repeat (count) random_request(empty_pct, behind_pct);
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part at the reset value of max_payload.
    offer_request(3'd0, 32'd0, 1'b1);
    offer_request(3'd0, 32'hFFFF_FFFF, 1'b1);
    offer_request(3'd1, 32'd0, 1'b0);
    offer_request(3'd7, 32'd24, 1'b0);           // lag right at the limit
    offer_request(3'd5, 32'd25, 1'b0);           // one line too far behind
    offer_request(3'd4, 32'hFFFF_FFFF, 1'b0);    // producer behind the reader wraps around
    offer_request(3'd6, 32'd0, 1'b0);
    offer_request(3'd3, 32'd2, 1'b0);
    offer_request(3'd6, 32'hFFFF_FFFF, 1'b0);
    offer_request(3'd2, 32'd0, 1'b0);
    write_max_payload(12'd4095);
    repeat (6) offer_request(3'd1, 32'd0, 1'b0); // runs into the end of a buffer
    write_max_payload(12'd13);
    repeat (2) offer_request(3'd4, 32'd1, 1'b0);
    write_max_payload(12'd12);
    repeat (2) offer_request(3'd2, 32'd0, 1'b0);
    write_max_payload(12'd0);
    offer_request(3'd7, 32'd24, 1'b0);

    // The receiver holds off while requests keep coming, so the input stalls.
    write_max_payload(12'd3072);
    hold_off = 40;
    repeat (80) random_request(10, 5);
    // Long clean stretch at the largest payload to cross frame boundaries.
    run_phase(12'd4095, 380, 5, 0);
    run_phase(12'd13, 40, 10, 10);
    run_phase(12'd12, 20, 10, 10);
    run_phase(12'($urandom_range(13, 3072)), 60, 10, 5);
    bursts_on = 1'b0;
    run_phase(12'd3072, 60, 5, 5);

    wait_drained();
    repeat (10) @(negedge clk_i);
    $display("Sent %0d requests and checked %0d descriptors, with %0d frame ends and %0d resyncs.",
             requests, descriptors, frame_ends, resyncs);
    $display("max_payload went through 3072, 4095, 13, 12, 0 and a random in-range value.");
    if (fail_count == 0 && pending_results == 0) begin
      $display("uvc_fragment_payload_packetizer_top: match");
    end else begin
      $display("uvc_fragment_payload_packetizer_top: mismatch");
    end
    $finish;
  end

endmodule

### files.f
rtl/ufpp_pkg.sv
rtl/ufpp_core.sv
rtl/uvc_fragment_payload_packetizer_top.sv
rtl/ufpp_checker.sv
tb/ufpp_payload_checker.sv
tb/tb_top.sv
